@@ src/takf_pkg.sv @@
// Package with the shared types, widths and saturation helpers of the tilt filter.
package takf_pkg;

  localparam int SW   = 32;  // sample width, Q16.16
  localparam int CF   = 24;  // covariance fraction bits
  localparam int OPW  = 35;  // multiplier and divider operand width
  localparam int PRW  = 2 * OPW;  // full product width
  localparam int MRW  = PRW - CF; // product width after the fraction shift
  localparam int QW   = SW + CF;  // dividend and quotient width
  localparam int CIW  = 2;        // configuration index width

  localparam logic [CIW-1:0] CFG_ANGLE_Q = 2'd0;
  localparam logic [CIW-1:0] CFG_BIAS_Q  = 2'd1;
  localparam logic [CIW-1:0] CFG_MEAS_R  = 2'd2;
  localparam logic [CIW-1:0] CFG_DT      = 2'd3;

  typedef struct packed {
    logic signed [SW-1:0] angle_sample;
    logic signed [SW-1:0] rate_sample;
  } in_item_t;

  typedef struct packed {
    logic signed [SW-1:0] angle_estimate_out;
    logic signed [SW-1:0] rate_corrected_out;
  } out_item_t;

  function automatic logic signed [SW-1:0] sat32(input logic signed [47:0] x);
    logic signed [SW-1:0] r;
    if (x > 48'sh00007FFFFFFF) r = 32'sh7FFFFFFF;
    else if (x < -48'sh000080000000) r = 32'sh80000000;
    else r = x[SW-1:0];
    return r;
  endfunction

  function automatic logic signed [47:0] sx48(input logic signed [SW-1:0] v);
    return $signed({{(48-SW){v[SW-1]}}, v});
  endfunction

  function automatic logic signed [OPW-1:0] sx35(input logic signed [SW-1:0] v);
    return $signed({{(OPW-SW){v[SW-1]}}, v});
  endfunction

endpackage

@@ src/takf_mul.sv @@
// Serial signed multiplier, one multiplier bit per cycle, result shifted by the fraction bits.
module takf_mul (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic signed [takf_pkg::OPW-1:0]     a_i,
  input  logic signed [takf_pkg::OPW-1:0]     b_i,
  output logic                                done_o,
  output logic signed [takf_pkg::MRW-1:0]     res_o
);

  logic [takf_pkg::OPW-1:0] mcand_q;
  logic [takf_pkg::PRW-1:0] prod_q;
  logic                     neg_q;
  logic [5:0]               cnt_q;
  logic                     done_q;
  logic [takf_pkg::OPW:0]   sum;
  logic signed [takf_pkg::PRW-1:0] sprod;

  assign sum = {1'b0, prod_q[takf_pkg::PRW-1:takf_pkg::OPW]} +
               (prod_q[0] ? {1'b0, mcand_q} : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= (cnt_q == 6'd1);
      if (start_i) begin
        cnt_q <= 6'(takf_pkg::OPW);
      end else if (cnt_q != 6'd0) begin
        cnt_q <= cnt_q - 6'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mcand_q <= a_i[takf_pkg::OPW-1] ? 35'(-a_i) : a_i;
      prod_q  <= {{takf_pkg::OPW{1'b0}}, (b_i[takf_pkg::OPW-1] ? 35'(-b_i) : b_i)};
      neg_q   <= a_i[takf_pkg::OPW-1] ^ b_i[takf_pkg::OPW-1];
    end else if (cnt_q != 6'd0) begin
      prod_q <= {sum, prod_q[takf_pkg::OPW-1:1]};
    end
  end

  // The two's complement of the magnitude, cut above the fraction, rounds toward minus infinity.
  assign sprod  = neg_q ? $signed(-prod_q) : $signed(prod_q);
  assign res_o  = sprod[takf_pkg::PRW-1:takf_pkg::CF];
  assign done_o = done_q;

endmodule

@@ src/takf_div.sv @@
// Serial restoring divider for the Kalman gains, one quotient bit per cycle, saturated.
module takf_div (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic signed [takf_pkg::SW-1:0]   num_i,
  input  logic signed [takf_pkg::OPW-1:0]  den_i,
  output logic                             done_o,
  output logic signed [takf_pkg::SW-1:0]   quo_o
);

  logic [takf_pkg::QW-1:0]  dvd_q;
  logic [takf_pkg::OPW-1:0] rem_q;
  logic [takf_pkg::OPW-1:0] ud_q;
  logic                     neg_q;
  logic                     zero_q;
  logic [5:0]               cnt_q;
  logic                     done_q;
  logic [takf_pkg::OPW:0]   shifted;
  logic [takf_pkg::OPW+1:0] trial;
  logic [takf_pkg::SW-1:0]  unum;

  assign unum    = num_i[takf_pkg::SW-1] ? 32'(-num_i) : num_i;
  assign shifted = {rem_q, dvd_q[takf_pkg::QW-1]};
  assign trial   = {1'b0, shifted} - {2'b00, ud_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= (cnt_q == 6'd1);
      if (start_i) begin
        cnt_q <= 6'(takf_pkg::QW);
      end else if (cnt_q != 6'd0) begin
        cnt_q <= cnt_q - 6'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q  <= {unum, {takf_pkg::CF{1'b0}}};
      rem_q  <= '0;
      ud_q   <= den_i[takf_pkg::OPW-1] ? 35'(-den_i) : den_i;
      neg_q  <= num_i[takf_pkg::SW-1] ^ den_i[takf_pkg::OPW-1];
      zero_q <= (den_i == '0);
    end else if (cnt_q != 6'd0) begin
      if (!trial[takf_pkg::OPW+1]) begin
        rem_q <= trial[takf_pkg::OPW-1:0];
        dvd_q <= {dvd_q[takf_pkg::QW-2:0], 1'b1};
      end else begin
        rem_q <= shifted[takf_pkg::OPW-1:0];
        dvd_q <= {dvd_q[takf_pkg::QW-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    if (zero_q) begin
      quo_o = '0;
    end else if (neg_q) begin
      quo_o = (dvd_q > 56'd2147483648) ? 32'sh80000000 : $signed(~dvd_q[31:0] + 32'd1);
    end else begin
      quo_o = (dvd_q > 56'd2147483647) ? 32'sh7FFFFFFF : $signed(dvd_q[31:0]);
    end
  end

  assign done_o = done_q;

endmodule

@@ src/tilt_angle_kalman_filter.sv @@
// Top level of the two-state tilt Kalman filter: sequencer, state, configuration and handshakes.
// Each item takes 10 multiplies and 2 gain divisions on the shared serial units, after it is
// accepted and before its result is delivered. The input stays stalled until the pass is done,
// so one item is processed at a time; the multiplier bit loop and the divider bit loop set the pace.
// A new item is accepted while the previous result still waits at the output register.
// Reset (rst_ni low, asynchronous) clears estimate and bias, sets the covariance to the identity
// and loads the default noise settings and sample period.
module tilt_angle_kalman_filter (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  takf_pkg::in_item_t            in_item_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output takf_pkg::out_item_t           out_item_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [takf_pkg::CIW-1:0]      cfg_index_i,
  input  logic [31:0]                   cfg_data_i
);

  // Sequencer states.
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_WAIT = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  // Steps of one filter pass. The four predict multiplies come first, then both gains,
  // then the covariance, angle and bias corrections.
  localparam logic [3:0] SP_ANGLE = 4'd0;
  localparam logic [3:0] SP_P00   = 4'd1;
  localparam logic [3:0] SP_PX    = 4'd2;
  localparam logic [3:0] SP_P11   = 4'd3;
  localparam logic [3:0] SP_K0    = 4'd4;
  localparam logic [3:0] SP_K1    = 4'd5;
  localparam logic [3:0] SU_C00   = 4'd6;
  localparam logic [3:0] SU_C01   = 4'd7;
  localparam logic [3:0] SU_C10   = 4'd8;
  localparam logic [3:0] SU_C11   = 4'd9;
  localparam logic [3:0] SU_ANGLE = 4'd10;
  localparam logic [3:0] SU_BIAS  = 4'd11;

  logic [1:0] state_q, state_d;
  logic [3:0] step_q;

  // Settings.
  logic [31:0] qa_q, qb_q, r_q, dt_q;

  // Filter state.
  logic signed [31:0] ang_q, bias_q, caa_q, cab_q, cba_q, cbb_q;

  // Per-item working registers.
  logic signed [31:0] meas_q, rate_q, p00_q, p01_q, p10_q, p11_q, k0_q, k1_q;
  logic signed [takf_pkg::OPW-1:0] err_q, e_q;

  logic out_valid_q;
  takf_pkg::out_item_t out_q;

  logic mul_start, div_start, mul_done, div_done, op_done, is_div;
  logic signed [takf_pkg::OPW-1:0] op_a, op_b;
  logic signed [takf_pkg::MRW-1:0] mul_res;
  logic signed [31:0] div_res, div_num;
  logic signed [47:0] r48;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  assign is_div    = (step_q == SP_K0) || (step_q == SP_K1);
  assign mul_start = (state_q == ST_RUN) && !is_div;
  assign div_start = (state_q == ST_RUN) && is_div;
  assign op_done   = mul_done | div_done;
  assign div_num   = (step_q == SP_K0) ? p00_q : p10_q;
  assign r48       = $signed({{(48 - takf_pkg::MRW){mul_res[takf_pkg::MRW-1]}}, mul_res});

  // Operand selection for the shared multiplier.
  always_comb begin
    op_a = '0;
    op_b = '0;
    unique case (step_q)
      SP_ANGLE: begin
        op_a = takf_pkg::sx35(rate_q) - takf_pkg::sx35(bias_q);
        op_b = $signed({3'b000, dt_q});
      end
      SP_P00: begin
        op_a = $signed({3'b000, qa_q}) - takf_pkg::sx35(cab_q) - takf_pkg::sx35(cba_q);
        op_b = $signed({3'b000, dt_q});
      end
      SP_PX: begin
        op_a = -takf_pkg::sx35(cbb_q);
        op_b = $signed({3'b000, dt_q});
      end
      SP_P11: begin
        op_a = $signed({3'b000, qb_q});
        op_b = $signed({3'b000, dt_q});
      end
      SU_C00: begin
        op_a = takf_pkg::sx35(k0_q);
        op_b = takf_pkg::sx35(p00_q);
      end
      SU_C01: begin
        op_a = takf_pkg::sx35(k0_q);
        op_b = takf_pkg::sx35(p01_q);
      end
      SU_C10: begin
        op_a = takf_pkg::sx35(k1_q);
        op_b = takf_pkg::sx35(p00_q);
      end
      SU_C11: begin
        op_a = takf_pkg::sx35(k1_q);
        op_b = takf_pkg::sx35(p01_q);
      end
      SU_ANGLE: begin
        op_a = takf_pkg::sx35(k0_q);
        op_b = err_q;
      end
      SU_BIAS: begin
        op_a = takf_pkg::sx35(k1_q);
        op_b = err_q;
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  takf_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (op_a),
    .b_i     (op_b),
    .done_o  (mul_done),
    .res_o   (mul_res)
  );

  takf_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (e_q),
    .done_o  (div_done),
    .quo_o   (div_res)
  );

  // Next state of the sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_RUN;
      ST_RUN:  state_d = ST_WAIT;
      ST_WAIT: begin
        if (op_done) state_d = (step_q == SU_BIAS) ? ST_OUT : ST_RUN;
      end
      ST_OUT:  if (!out_valid_q || !out_stall_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= SP_ANGLE;
      out_valid_q <= 1'b0;
      qa_q        <= 32'd16777;
      qb_q        <= 32'd50332;
      r_q         <= 32'd8388608;
      dt_q        <= 32'd83886;
      ang_q       <= '0;
      bias_q      <= '0;
      caa_q       <= 32'sd1 <<< takf_pkg::CF;
      cab_q       <= '0;
      cba_q       <= '0;
      cbb_q       <= 32'sd1 <<< takf_pkg::CF;
    end else begin
      state_q <= state_d;

      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          takf_pkg::CFG_ANGLE_Q: qa_q <= cfg_data_i;
          takf_pkg::CFG_BIAS_Q:  qb_q <= cfg_data_i;
          takf_pkg::CFG_MEAS_R:  r_q  <= cfg_data_i;
          takf_pkg::CFG_DT:      dt_q <= cfg_data_i;
          default: ;
        endcase
      end

      if (state_q == ST_IDLE && in_valid_i) step_q <= SP_ANGLE;

      if (state_q == ST_WAIT && op_done) begin
        step_q <= step_q + 4'd1;
        unique case (step_q)
          SP_ANGLE: ang_q <= takf_pkg::sat32(takf_pkg::sx48(ang_q) + r48);
          SP_P00:   p00_q <= takf_pkg::sat32(takf_pkg::sx48(caa_q) + r48);
          SP_PX: begin
            p01_q <= takf_pkg::sat32(takf_pkg::sx48(cab_q) + r48);
            p10_q <= takf_pkg::sat32(takf_pkg::sx48(cba_q) + r48);
          end
          SP_P11:   p11_q <= takf_pkg::sat32(takf_pkg::sx48(cbb_q) + r48);
          SP_K0:    k0_q  <= div_res;
          SP_K1:    k1_q  <= div_res;
          SU_C00:   caa_q <= takf_pkg::sat32(takf_pkg::sx48(p00_q) - r48);
          SU_C01:   cab_q <= takf_pkg::sat32(takf_pkg::sx48(p01_q) - r48);
          SU_C10:   cba_q <= takf_pkg::sat32(takf_pkg::sx48(p10_q) - r48);
          SU_C11:   cbb_q <= takf_pkg::sat32(takf_pkg::sx48(p11_q) - r48);
          SU_ANGLE: ang_q <= takf_pkg::sat32(takf_pkg::sx48(ang_q) + r48);
          SU_BIAS:  bias_q <= takf_pkg::sat32(takf_pkg::sx48(bias_q) + r48);
          default: ;
        endcase
      end

      // A finished pass loads the output register when it is empty or as the previous result leaves.
      if (state_q == ST_OUT && (!out_valid_q || !out_stall_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_valid_i) begin
      meas_q <= in_item_i.angle_sample;
      rate_q <= in_item_i.rate_sample;
    end
    // The innovation and its variance follow once the predict step is complete.
    if (state_q == ST_WAIT && op_done && step_q == SP_P11) begin
      err_q <= takf_pkg::sx35(meas_q) - takf_pkg::sx35(ang_q);
      e_q   <= $signed({3'b000, r_q}) + takf_pkg::sx35(p00_q);
    end
    if (state_q == ST_OUT && (!out_valid_q || !out_stall_i)) begin
      out_q.angle_estimate_out <= ang_q;
      out_q.rate_corrected_out <=
        takf_pkg::sat32(takf_pkg::sx48(rate_q) - takf_pkg::sx48(bias_q));
    end
  end

endmodule

@@ src/takf_checker.sv @@
// Port checker for the tilt filter, bound to the top level.
module takf_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_stall_o,
  input logic                      out_valid_o,
  input logic                      out_stall_i,
  input logic                      cfg_valid_i,
  input logic                      cfg_ready_o
);

  // A result that is stalled stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // An accepted item keeps the input side stalled while it is processed.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after an accepted item");

  // A new result appears only at the end of a pass.
  a_rose: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without an item in flight");

  // Configuration is always taken.
  a_cfg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("configuration write refused");

endmodule

bind tilt_angle_kalman_filter takf_checker u_takf_checker (.*);
